/* design/dtes_pkg.sv */
// Shared types, constants and the month table for the date-to-epoch pipeline.
// Used by every dtes_* stage and by datetime_to_epoch_seconds_core.
`timescale 1ns / 1ps

package dtes_pkg;

	// Calendar and time constants
	localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
	localparam logic [11:0] VALID_YEAR_LOW     = 12'd2000;
	localparam logic [11:0] VALID_YEAR_HIGH    = 12'd2099;
	localparam logic [3:0]  MONTHS_PER_YEAR    = 4'd12;
	localparam logic [4:0]  HOURS_PER_DAY      = 5'd24;
	localparam logic [5:0]  MINUTES_PER_HOUR   = 6'd60;
	localparam logic [5:0]  SECONDS_PER_MINUTE = 6'd60;
	localparam logic [16:0] SECS_PER_HOUR      = 17'd3600;
	localparam logic [16:0] SECS_PER_MINUTE    = 17'd60;
	localparam logic [31:0] SECS_PER_DAY       = 32'd86400;
	localparam logic [19:0] DAYS_PER_YEAR      = 20'd365;

	// Leap years in 1..1969: 492 - 19 + 4
	localparam logic [19:0] LEAPS_BEFORE_EPOCH = 20'd477;

	// Divide by 100 for 12-bit values: (x * 5243) >> 19 is exact below 4096
	localparam int          RECIP_SHIFT = 19;
	localparam int          PROD_W      = 26;
	localparam int          CENT_W      = 6;
	localparam logic [PROD_W-1:0] RECIP_100 = PROD_W'(5243);
	localparam logic [11:0] HUNDRED     = 12'd100;

	// Widths of intermediate values
	localparam int YEAR_DAYS_W = 20;
	localparam int DAYS_W      = 22;
	localparam int TOD_W       = 17;

	// Input word fields
	typedef struct packed {
		logic [2:0]  weekday;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} date_in_t;

	// After stage 1: centuries and month index
	typedef struct packed {
		logic [11:0]       year;
		logic [CENT_W-1:0] cent_y;
		logic [CENT_W-1:0] cent_ym1;
		logic [3:0]        month_idx;
		logic [4:0]        day;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
		logic              fields_valid;
	} split_t;

	// After stage 2: days of whole years, leap flag, time of day
	typedef struct packed {
		logic [YEAR_DAYS_W-1:0] year_days;
		logic                   leap;
		logic [3:0]             month_idx;
		logic [4:0]             day;
		logic [TOD_W-1:0]       tod;
		logic                   fields_valid;
	} span_t;

	// After stage 3: total days (two's complement, may be minus one)
	typedef struct packed {
		logic [DAYS_W-1:0] days;
		logic [TOD_W-1:0]  tod;
		logic              fields_valid;
	} days_t;

	// Result word
	typedef struct packed {
		logic [31:0] epoch_seconds;
		logic        fields_valid;
	} result_t;

	// Days before the month at index idx; index 12 gives the whole year
	function automatic logic [8:0] days_before(input logic leap, input logic [3:0] idx);
		logic [8:0] base;
		base = 9'd0;
		case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			4'd12:   base = 9'd365;
			default: base = 9'd0;
		endcase
		if (leap && (idx >= 4'd2)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

/* design/dtes_split.sv */
// Stage 1: divide year and year-1 by 100, clamp the month index, check ranges.
// Depends on dtes_pkg.
`timescale 1ns / 1ps

module dtes_split (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dtes_pkg::date_in_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output dtes_pkg::split_t  out_data
);
	import dtes_pkg::*;

	logic              valid_s1;
	split_t            data_s1;
	logic [11:0]       year_m1;
	logic [PROD_W-1:0] prod_y;
	logic [PROD_W-1:0] prod_ym1;
	logic [3:0]        month_idx;
	logic              in_range;

	// Take a word whenever this stage is empty or drains this cycle
	assign in_ready = !valid_s1 || out_ready;

	// Divide by 100 through the reciprocal
	always_comb begin
		year_m1  = in_data.year - 12'd1;
		prod_y   = PROD_W'(in_data.year) * RECIP_100;
		prod_ym1 = PROD_W'(year_m1) * RECIP_100;
	end

	// Clamp the count of prior months
	always_comb begin
		if (in_data.month == 4'd0) begin
			month_idx = 4'd0;
		end else if (in_data.month > MONTHS_PER_YEAR) begin
			month_idx = MONTHS_PER_YEAR;
		end else begin
			month_idx = in_data.month - 4'd1;
		end
	end

	// Range checks; day and weekday cannot exceed their maxima in their widths
	always_comb begin
		in_range = (in_data.second < SECONDS_PER_MINUTE) &&
			(in_data.minute < MINUTES_PER_HOUR) &&
			(in_data.hour < HOURS_PER_DAY) &&
			(in_data.year >= VALID_YEAR_LOW) && (in_data.year <= VALID_YEAR_HIGH) &&
			(in_data.month != 4'd0) && (in_data.month <= MONTHS_PER_YEAR) &&
			(in_data.day != 5'd0) && (in_data.weekday != 3'd0);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Load payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.year         <= in_data.year;
			data_s1.cent_y       <= prod_y[RECIP_SHIFT +: CENT_W];
			data_s1.cent_ym1     <= prod_ym1[RECIP_SHIFT +: CENT_W];
			data_s1.month_idx    <= month_idx;
			data_s1.day          <= in_data.day;
			data_s1.hour         <= in_data.hour;
			data_s1.minute       <= in_data.minute;
			data_s1.second       <= in_data.second;
			data_s1.fields_valid <= in_range;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

/* design/dtes_span.sv */
// Stage 2: days in whole years since the epoch, leap flag, seconds of the day.
// Depends on dtes_pkg.
`timescale 1ns / 1ps

module dtes_span (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dtes_pkg::split_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output dtes_pkg::span_t  out_data
);
	import dtes_pkg::*;

	logic                   valid_s2;
	span_t                  data_s2;
	logic [11:0]            year_m1;
	logic [11:0]            span_years;
	logic [YEAR_DAYS_W-1:0] plain_days;
	logic [YEAR_DAYS_W-1:0] leap_days;
	logic [YEAR_DAYS_W-1:0] year_days;
	logic [11:0]            cent_x100;
	logic                   leap;
	logic [TOD_W-1:0]       tod;

	assign in_ready = !valid_s2 || out_ready;

	// Whole years from the epoch up to the given year, none before it
	always_comb begin
		year_m1    = in_data.year - 12'd1;
		span_years = in_data.year - EPOCH_YEAR;
		plain_days = YEAR_DAYS_W'(span_years) * DAYS_PER_YEAR;
		leap_days  = YEAR_DAYS_W'(year_m1[11:2]) - YEAR_DAYS_W'(in_data.cent_ym1) +
			YEAR_DAYS_W'(in_data.cent_ym1[CENT_W-1:2]) - LEAPS_BEFORE_EPOCH;
		year_days  = (in_data.year > EPOCH_YEAR) ? (plain_days + leap_days) :
			YEAR_DAYS_W'(0);
	end

	// Gregorian leap rule on the given year
	always_comb begin
		cent_x100 = 12'(in_data.cent_y) * HUNDRED;
		leap = (in_data.year[1:0] == 2'b00) &&
			((in_data.year != cent_x100) || (in_data.cent_y[1:0] == 2'b00));
	end

	// Seconds of the day, unlimited hour, minute and second
	always_comb begin
		tod = TOD_W'(in_data.hour) * SECS_PER_HOUR +
			TOD_W'(in_data.minute) * SECS_PER_MINUTE + TOD_W'(in_data.second);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// Load payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2.year_days    <= year_days;
			data_s2.leap         <= leap;
			data_s2.month_idx    <= in_data.month_idx;
			data_s2.day          <= in_data.day;
			data_s2.tod          <= tod;
			data_s2.fields_valid <= in_data.fields_valid;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* design/dtes_days.sv */
// Stage 3: add the prior months and the day of month to the year days.
// Depends on dtes_pkg (month table).
`timescale 1ns / 1ps

module dtes_days (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dtes_pkg::span_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output dtes_pkg::days_t out_data
);
	import dtes_pkg::*;

	logic              valid_s3;
	days_t             data_s3;
	logic [DAYS_W-1:0] days;

	assign in_ready = !valid_s3 || out_ready;

	// Day zero gives minus one day, kept in two's complement
	always_comb begin
		days = DAYS_W'(in_data.year_days) +
			DAYS_W'(days_before(in_data.leap, in_data.month_idx)) +
			DAYS_W'(in_data.day) - DAYS_W'(1);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// Load payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3.days         <= days;
			data_s3.tod          <= in_data.tod;
			data_s3.fields_valid <= in_data.fields_valid;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

/* design/dtes_secs.sv */
// Stage 4: scale days to seconds, add the time of day; holds the result word.
// Depends on dtes_pkg.
`timescale 1ns / 1ps

module dtes_secs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dtes_pkg::days_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output dtes_pkg::result_t out_data
);
	import dtes_pkg::*;

	logic        valid_s4;
	result_t     data_s4;
	logic [31:0] days_ext;
	logic [31:0] secs;

	assign in_ready = !valid_s4 || out_ready;

	// Sign-extend days and wrap the seconds modulo 2^32
	always_comb begin
		days_ext = {{(32 - DAYS_W){in_data.days[DAYS_W-1]}}, in_data.days};
		secs     = days_ext * SECS_PER_DAY + 32'(in_data.tod);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	// Load result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s4.epoch_seconds <= secs;
			data_s4.fields_valid  <= in_data.fields_valid;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

/* design/datetime_to_epoch_seconds_core.sv */
// Calendar date and time to seconds since 1970-01-01, four-stage pipeline.
// Depends on dtes_pkg, dtes_split, dtes_span, dtes_days and dtes_secs.
//
// Usage:
//   Input words arrive on s_axis: year, month, day, hour, minute, second and
//   weekday packed in s_axis_tdata. Each word yields one output word on
//   m_axis: epoch seconds (modulo 2^32) in m_axis_tdata and the field range
//   check in m_axis_tuser.
//   Each word passes through the four register stages (divide by 100,
//   year days and time of day, month and day add, scale to seconds);
//   throughput is one word per cycle while m_axis_tready stays high.
//   Each stage holds its own word and loads whenever it is empty or its
//   successor takes its word, so bubbles close up during a stall. When
//   m_axis_tready is low the result holds on m_axis, and s_axis_tready stays
//   high until all four stages are full.
//   Reset (arst_n low) empties the pipeline at once; no output words remain.
`timescale 1ns / 1ps

module datetime_to_epoch_seconds_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [11:0] year_value, [15:12] month_value, [20:16] day_value,
	// [25:21] hour_value, [31:26] minute_value, [37:32] second_value,
	// [40:38] weekday_value, [47:41] zero
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] epoch_seconds
	output logic [31:0] m_axis_tdata,
	// [0] fields_valid
	output logic [0:0]  m_axis_tuser
);
	import dtes_pkg::*;

	date_in_t in_word;
	split_t   split_data;
	span_t    span_data;
	days_t    days_data;
	result_t  result_data;
	logic     split_valid, split_ready;
	logic     span_valid, span_ready;
	logic     days_valid, days_ready;

	// Unpack the input word
	always_comb begin
		in_word.year    = s_axis_tdata[11:0];
		in_word.month   = s_axis_tdata[15:12];
		in_word.day     = s_axis_tdata[20:16];
		in_word.hour    = s_axis_tdata[25:21];
		in_word.minute  = s_axis_tdata[31:26];
		in_word.second  = s_axis_tdata[37:32];
		in_word.weekday = s_axis_tdata[40:38];
	end

	dtes_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (in_word),
		.out_valid (split_valid),
		.out_ready (split_ready),
		.out_data  (split_data)
	);

	dtes_span u_span (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (split_ready),
		.in_data   (split_data),
		.out_valid (span_valid),
		.out_ready (span_ready),
		.out_data  (span_data)
	);

	dtes_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (span_valid),
		.in_ready  (span_ready),
		.in_data   (span_data),
		.out_valid (days_valid),
		.out_ready (days_ready),
		.out_data  (days_data)
	);

	dtes_secs u_secs (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (days_valid),
		.in_ready  (days_ready),
		.in_data   (days_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (result_data)
	);

	// Drive the output word
	assign m_axis_tdata = result_data.epoch_seconds;
	assign m_axis_tuser = result_data.fields_valid;

endmodule
